// ----- rtl/core/fpn_pkg.sv -----
// shared types, constants and the gradient helper function for the fractal perlin noise block
`timescale 1ns / 1ps
`default_nettype none
package fpn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int OCT_CNT_W   = $clog2(MAX_OCTAVES + 1);
    localparam int TOT_W       = 56;
    localparam int WSUM_W      = 37;
    localparam int DIV_CNT_W   = $clog2(TOT_W);
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0] BASE_FREQ_RST = 32'd335544;
    localparam logic [3:0]  OCT_COUNT_RST = 4'd4;
    localparam logic [15:0] PERSIST_RST   = 16'd16384;
    localparam logic [15:0] LACUN_RST     = 16'd8192;
    localparam logic [15:0] AMPL_RST      = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FREQ = 3'd0,
        CFG_OFFSET_X  = 3'd1,
        CFG_OFFSET_Z  = 3'd2,
        CFG_OCT_COUNT = 3'd3,
        CFG_PERSIST   = 3'd4,
        CFG_LACUN     = 3'd5,
        CFG_AMPL      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] base_frequency;
        logic [31:0] offset_x;
        logic [31:0] offset_z;
        logic [3:0]  octave_count;
        logic [15:0] persistence;
        logic [15:0] lacunarity;
        logic [15:0] amplitude;
    } cfg_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_MX, ST_MZ,
        ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_RD5,
        ST_RD6, ST_RD7, ST_RD8, ST_RD9, ST_RD10,
        ST_FX0, ST_FX1, ST_FX2, ST_FX3,
        ST_FZ0, ST_FZ1, ST_FZ2, ST_FZ3,
        ST_L0, ST_L1, ST_L2, ST_ACC, ST_UPD,
        ST_DIVI, ST_DIV, ST_SCALE, ST_FIN
    } step_t;

    typedef struct packed {
        step_t step;
        logic  eval_go;
        logic  load_go;
    } cmd_t;

    // eight-way gradient: +-u +- 2v
    function automatic logic signed [19:0] grad(input logic [2:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic signed [19:0] r;
        u = h[2] ? y : x;
        v = h[2] ? x : y;
        r = h[0] ? -u : u;
        r = h[1] ? (r - (v <<< 1)) : (r + (v <<< 1));
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fpn_ctrl.sv -----
// sequencer for table loads, octave steps, division and result
`timescale 1ns / 1ps
`default_nettype none
module fpn_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          req_type,
    input  wire logic [3:0]    octave_count,
    output fpn_pkg::cmd_t      cmd,
    output logic               busy
);
    import fpn_pkg::*;

    step_t                 state_reg, state_next;
    logic [OCT_CNT_W-1:0]  oct_reg, oct_next;
    logic [OCT_CNT_W-1:0]  n_reg, n_next;
    logic [DIV_CNT_W-1:0]  div_reg, div_next;
    logic [4:0]            oc_ext;
    logic                  last_oct;

    assign oc_ext   = {1'b0, octave_count};
    assign last_oct = (oct_reg == n_reg - OCT_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oct_reg   <= '0;
            n_reg     <= OCT_CNT_W'(1);
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            oct_reg   <= oct_next;
            n_reg     <= n_next;
            div_reg   <= div_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        oct_next   = oct_reg;
        n_next     = n_reg;
        div_next   = div_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !req_type)
                begin
                    state_next = ST_MX;
                    oct_next   = '0;
                    if (oc_ext == 5'd0)
                        n_next = OCT_CNT_W'(1);
                    else if (oc_ext > 5'(MAX_OCTAVES))
                        n_next = OCT_CNT_W'(MAX_OCTAVES);
                    else
                        n_next = OCT_CNT_W'(oc_ext);
                end
            end
            ST_MX:    state_next = ST_MZ;
            ST_MZ:    state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_RD3;
            ST_RD3:   state_next = ST_RD4;
            ST_RD4:   state_next = ST_RD5;
            ST_RD5:   state_next = ST_RD6;
            ST_RD6:   state_next = ST_RD7;
            ST_RD7:   state_next = ST_RD8;
            ST_RD8:   state_next = ST_RD9;
            ST_RD9:   state_next = ST_RD10;
            ST_RD10:  state_next = ST_FX0;
            ST_FX0:   state_next = ST_FX1;
            ST_FX1:   state_next = ST_FX2;
            ST_FX2:   state_next = ST_FX3;
            ST_FX3:   state_next = ST_FZ0;
            ST_FZ0:   state_next = ST_FZ1;
            ST_FZ1:   state_next = ST_FZ2;
            ST_FZ2:   state_next = ST_FZ3;
            ST_FZ3:   state_next = ST_L0;
            ST_L0:    state_next = ST_L1;
            ST_L1:    state_next = ST_L2;
            ST_L2:    state_next = ST_ACC;
            ST_ACC:   state_next = ST_UPD;
            ST_UPD:
            begin
                if (last_oct)
                    state_next = ST_DIVI;
                else
                begin
                    state_next = ST_MX;
                    oct_next   = oct_reg + OCT_CNT_W'(1);
                end
            end
            ST_DIVI:
            begin
                state_next = ST_DIV;
                div_next   = '0;
            end
            ST_DIV:
            begin
                if (div_reg == DIV_CNT_W'(TOT_W - 1))
                    state_next = ST_SCALE;
                else
                    div_next = div_reg + DIV_CNT_W'(1);
            end
            ST_SCALE: state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd.step    = state_reg;
        cmd.eval_go = (state_reg == ST_IDLE) && start && !req_type;
        cmd.load_go = (state_reg == ST_IDLE) && start && req_type;
        busy        = (state_reg != ST_IDLE);
    end

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg <= DIV_CNT_W'(TOT_W - 1)))
        else $error("divider step count overrun");
    a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (oct_reg < n_reg))
        else $error("octave counter beyond octave count");
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_IDLE))
        else $error("result step not followed by idle");
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg >= OCT_CNT_W'(1)) && (n_reg <= OCT_CNT_W'(MAX_OCTAVES)))
        else $error("octave count out of range");

endmodule
`default_nettype wire

// ----- rtl/core/fpn_datapath.sv -----
// noise datapath: permutation memory, fade, gradients, accumulation, divider, scaling and clipping
`timescale 1ns / 1ps
`default_nettype none
module fpn_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fpn_pkg::cmd_t cmd,
    input  wire fpn_pkg::cfg_t cfg,
    input  wire logic [31:0]   x_coord,
    input  wire logic [31:0]   z_coord,
    input  wire logic [7:0]    entry_index,
    input  wire logic [7:0]    entry_value,
    output logic               done,
    output logic [23:0]        height,
    output logic               saturated
);
    import fpn_pkg::*;

    logic [7:0] perm_mem [256];
    logic [7:0] mem_q;
    logic [7:0] rd_addr;

    logic signed [31:0]       x_reg, z_reg;
    logic [31:0]              f_reg, w_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic [WSUM_W-1:0]        wsum_reg;
    logic [23:0]              px_reg, pz_reg;
    logic [7:0]               pa_reg, a_reg, b_reg;
    logic [7:0]               aa_reg, ab_reg, ba_reg, bb_reg;
    logic [7:0]               h00_reg, h01_reg, h10_reg, h11_reg;
    logic [15:0]              t2_reg, t3_reg;
    logic [20:0]              q_reg;
    logic [16:0]              u_reg, v_reg;
    logic signed [23:0]       l0_reg, l1_reg, res_reg;
    logic [TOT_W-1:0]         num_reg;
    logic [WSUM_W:0]          rem_reg;
    logic                     neg_reg;
    logic signed [34:0]       hs_reg;
    logic                     done_reg;
    logic [23:0]              height_reg;
    logic                     sat_reg;

    logic [7:0]               cx, cz;
    logic [15:0]              fx, fz, ft;
    logic signed [17:0]       fxs, fzs, fx1, fz1;
    logic signed [19:0]       g00, g10, g01, g11;
    logic signed [64:0]       pm_x, pm_z;
    logic [31:0]              sq, cu;
    logic [18:0]              six;
    logic signed [20:0]       pv;
    logic signed [37:0]       tp;
    logic signed [21:0]       qs;
    logic [36:0]              uq;
    logic signed [38:0]       lp0, lp1;
    logic signed [42:0]       lp2;
    logic signed [24:0]       vsum;
    logic signed [23:0]       val;
    logic signed [56:0]       acc_p;
    logic [47:0]              wp, fp;
    logic [WSUM_W:0]          rs;
    logic signed [25:0]       avg;
    logic signed [42:0]       ap;

    assign cx  = px_reg[23:16];
    assign cz  = pz_reg[23:16];
    assign fx  = px_reg[15:0];
    assign fz  = pz_reg[15:0];
    assign fxs = $signed({2'b00, fx});
    assign fzs = $signed({2'b00, fz});
    assign fx1 = fxs - 18'sd65536;
    assign fz1 = fzs - 18'sd65536;
    assign g00 = grad(h00_reg[2:0], fxs, fzs);
    assign g10 = grad(h10_reg[2:0], fx1, fzs);
    assign g01 = grad(h01_reg[2:0], fxs, fz1);
    assign g11 = grad(h11_reg[2:0], fx1, fz1);

    // scaled sample positions, only bits 47:24 of the product matter
    assign pm_x = x_reg * $signed({1'b0, f_reg});
    assign pm_z = z_reg * $signed({1'b0, f_reg});

    // fade operand follows the step group
    always_comb
    begin
        case (cmd.step) inside
            ST_FZ0, ST_FZ1, ST_FZ2, ST_FZ3: ft = fz;
            default:                       ft = fx;
        endcase
    end

    assign sq   = ft * ft;
    assign cu   = t2_reg * ft;
    assign six  = {1'b0, ft, 2'b00} + {2'b00, ft, 1'b0};
    assign pv   = $signed({2'b00, six}) - 21'sd983040;
    assign tp   = $signed({1'b0, ft}) * pv;
    assign qs   = $signed(tp[37:16]) + 22'sd655360;
    assign uq   = t3_reg * q_reg;

    assign lp0  = $signed({1'b0, u_reg}) * (21'(g10) - 21'(g00));
    assign lp1  = $signed({1'b0, u_reg}) * (21'(g11) - 21'(g01));
    assign lp2  = $signed({1'b0, v_reg}) * (25'(l1_reg) - 25'(l0_reg));

    assign vsum = 25'(res_reg) + 25'sd65536;
    assign val  = vsum[24:1];
    assign acc_p = val * $signed({1'b0, w_reg});

    assign wp   = w_reg * cfg.persistence;
    assign fp   = f_reg * cfg.lacunarity;

    assign rs   = {rem_reg[WSUM_W-1:0], num_reg[TOT_W-1]};

    assign avg  = neg_reg ? -$signed({1'b0, num_reg[24:0]}) : $signed({1'b0, num_reg[24:0]});
    assign ap   = avg * $signed({1'b0, cfg.amplitude});

    // read address per lookup step
    always_comb
    begin
        case (cmd.step)
            ST_RD0:  rd_addr = cx;
            ST_RD1:  rd_addr = cx + 8'd1;
            ST_RD2:  rd_addr = pa_reg + cz;
            ST_RD3:  rd_addr = a_reg + 8'd1;
            ST_RD4:  rd_addr = b_reg;
            ST_RD5:  rd_addr = b_reg + 8'd1;
            ST_RD6:  rd_addr = aa_reg;
            ST_RD7:  rd_addr = ab_reg;
            ST_RD8:  rd_addr = ba_reg;
            ST_RD9:  rd_addr = bb_reg;
            default: rd_addr = cx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_go)
            perm_mem[entry_index] <= entry_value;
        mem_q <= perm_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_go)
        begin
            x_reg     <= $signed(x_coord);
            z_reg     <= $signed(z_coord);
            f_reg     <= cfg.base_frequency;
            w_reg     <= 32'd32768;
            total_reg <= '0;
            wsum_reg  <= '0;
        end
        case (cmd.step) inside
            ST_MX:  px_reg <= pm_x[47:24] + cfg.offset_x[23:0];
            ST_MZ:  pz_reg <= pm_z[47:24] + cfg.offset_z[23:0];
            ST_RD1: pa_reg <= mem_q;
            ST_RD2:
            begin
                a_reg <= rd_addr;
                b_reg <= mem_q + cz;
            end
            ST_RD3:  aa_reg  <= mem_q;
            ST_RD4:  ab_reg  <= mem_q;
            ST_RD5:  ba_reg  <= mem_q;
            ST_RD6:  bb_reg  <= mem_q;
            ST_RD7:  h00_reg <= mem_q;
            ST_RD8:  h01_reg <= mem_q;
            ST_RD9:  h10_reg <= mem_q;
            ST_RD10: h11_reg <= mem_q;
            ST_FX0, ST_FZ0: t2_reg <= sq[31:16];
            ST_FX1, ST_FZ1: t3_reg <= cu[31:16];
            ST_FX2, ST_FZ2: q_reg  <= qs[20:0];
            ST_FX3: u_reg <= uq[32:16];
            ST_FZ3: v_reg <= uq[32:16];
            // blend terms are signed, keep the sign through the shift
            ST_L0:  l0_reg  <= 24'(g00) + $signed(lp0[38:16]);
            ST_L1:  l1_reg  <= 24'(g01) + $signed(lp1[38:16]);
            ST_L2:  res_reg <= l0_reg + $signed(lp2[39:16]);
            ST_ACC:
            begin
                total_reg <= total_reg + acc_p[TOT_W-1:0];
                wsum_reg  <= wsum_reg + WSUM_W'(w_reg);
            end
            ST_UPD:
            begin
                w_reg <= (wp[47:47] != 1'b0) ? 32'hFFFF_FFFF : wp[46:15];
                f_reg <= (fp[47:44] != 4'd0) ? 32'hFFFF_FFFF : fp[43:12];
            end
            ST_DIVI:
            begin
                neg_reg <= total_reg[TOT_W-1];
                num_reg <= total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                if (rs >= {1'b0, wsum_reg})
                begin
                    rem_reg <= rs - {1'b0, wsum_reg};
                    num_reg <= {num_reg[TOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rs;
                    num_reg <= {num_reg[TOT_W-2:0], 1'b0};
                end
            end
            ST_SCALE: hs_reg <= ap[42:8];
            ST_FIN:
            begin
                if (hs_reg > 35'sd8388607)
                begin
                    height_reg <= 24'h7F_FFFF;
                    sat_reg    <= 1'b1;
                end
                else if (hs_reg < -35'sd8388608)
                begin
                    height_reg <= 24'h80_0000;
                    sat_reg    <= 1'b1;
                end
                else
                begin
                    height_reg <= hs_reg[23:0];
                    sat_reg    <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (cmd.step == ST_FIN);
    end

    assign done      = done_reg;
    assign height    = height_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

// ----- rtl/core/fractal_perlin_noise_2d.sv -----
// top level of the fractal perlin noise block: configuration registers and core
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// request   | start, busy               | req_type, x_coord, z_coord, entry_index,
//           |                           | entry_value
// result    | done (one-cycle strobe)   | height, saturated
// config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// a request transaction completes when start is high and busy is low
// a load transaction writes one table entry in that cycle and leaves busy low
// an evaluate transaction holds busy through the steps of each octave and then through
// division, scaling and clipping; division uses a 56-step restoring divider
// done pulses in the first cycle with busy low; the receiver cannot stall results
// reset clears control state and loads the config defaults; the table holds garbage until loaded
module fractal_perlin_noise_2d (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [31:0]                   x_coord,
    input  wire logic [31:0]                   z_coord,
    input  wire logic [7:0]                    entry_index,
    input  wire logic [7:0]                    entry_value,
    output logic                               done,
    output logic [23:0]                        height,
    output logic                               saturated,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fpn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import fpn_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    logic busy_int;

    // config writes always taken, block is idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_frequency <= BASE_FREQ_RST;
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_z       <= '0;
            cfg_reg.octave_count   <= OCT_COUNT_RST;
            cfg_reg.persistence    <= PERSIST_RST;
            cfg_reg.lacunarity     <= LACUN_RST;
            cfg_reg.amplitude      <= AMPL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes beyond the register list are dropped
            unique case (cfg_index)
                CFG_BASE_FREQ: cfg_reg.base_frequency <= cfg_data;
                CFG_OFFSET_X:  cfg_reg.offset_x       <= cfg_data;
                CFG_OFFSET_Z:  cfg_reg.offset_z       <= cfg_data;
                CFG_OCT_COUNT: cfg_reg.octave_count   <= cfg_data[3:0];
                CFG_PERSIST:   cfg_reg.persistence    <= cfg_data[15:0];
                CFG_LACUN:     cfg_reg.lacunarity     <= cfg_data[15:0];
                CFG_AMPL:      cfg_reg.amplitude      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer: one step per cycle, octave and divider counters
    fpn_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .octave_count (cfg_reg.octave_count),
        .cmd          (cmd),
        .busy         (busy_int)
    );

    // arithmetic and permutation memory driven by the step code
    fpn_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg_reg),
        .x_coord     (x_coord),
        .z_coord     (z_coord),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .done        (done),
        .height      (height),
        .saturated   (saturated)
    );

    assign busy = busy_int;

endmodule
`default_nettype wire
